>>> design/scrd_pkg.sv
package scrd_pkg;

    // Sync sequence bytes.
    localparam logic [7:0] SYNC_A = 8'hFA;
    localparam logic [7:0] SYNC_B = 8'hFB;
    localparam logic [7:0] SYNC_C = 8'hFC;

    // Payload geometry.
    localparam int unsigned MAX_LEN   = 8;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned ID_BYTES  = 4;
    localparam int unsigned ID_IDX_W  = 2;
    localparam logic [LEN_W-1:0] MAX_LEN_CODE = LEN_W'(MAX_LEN);

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_HUNT   = 6'b000001,
        PH_SYNC_B = 6'b000010,
        PH_SYNC_C = 6'b000100,
        PH_ID     = 6'b001000,
        PH_LEN    = 6'b010000,
        PH_DATA   = 6'b100000
    } scrd_phase_t;

    // One finished frame record.
    typedef struct packed {
        logic [31:0]      frame_id;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       data_0;
        logic [7:0]       data_1;
        logic [7:0]       data_2;
        logic [7:0]       data_3;
        logic [7:0]       data_4;
        logic [7:0]       data_5;
        logic [7:0]       data_6;
        logic [7:0]       data_7;
    } scrd_record_t;

endpackage

>>> design/scrd_if.sv
// Byte channel from the serial receiver.
interface scrd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Frame record channel.
interface scrd_rec_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_id;
    logic [3:0]  frame_length;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_4;
    logic [7:0]  data_5;
    logic [7:0]  data_6;
    logic [7:0]  data_7;

    modport source (
        output valid, output frame_id, output frame_length,
        output data_0, output data_1, output data_2, output data_3,
        output data_4, output data_5, output data_6, output data_7,
        input ready
    );
    modport sink (
        input valid, input frame_id, input frame_length,
        input data_0, input data_1, input data_2, input data_3,
        input data_4, input data_5, input data_6, input data_7,
        output ready
    );
endinterface

>>> design/scrd_parser.sv
module scrd_parser
    import scrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    input  logic [7:0]   byte_data,
    output logic         rec_push,
    output scrd_record_t rec_data
);

    scrd_phase_t            phase_reg, phase_next;
    logic [ID_IDX_W-1:0]    id_idx_reg, id_idx_next;
    logic [IDX_W-1:0]       data_idx_reg, data_idx_next;
    logic [LEN_W-1:0]       length_reg, length_next;
    logic [31:0]            id_reg, id_next;
    logic [7:0]             store_reg [MAX_LEN];
    logic [LEN_W-1:0]       len_sat;
    logic [LEN_W-1:0]       out_len;
    logic [LEN_W-1:0]       data_count;
    logic                   done;
    logic [7:0]             lane [MAX_LEN];

    // Saturate the received length byte.
    assign len_sat    = (byte_data > 8'(MAX_LEN)) ? MAX_LEN_CODE : byte_data[LEN_W-1:0];
    assign data_count = {1'b0, data_idx_reg} + LEN_W'(1);

    // Phase sequencing and field capture for one accepted byte.
    always_comb
    begin
        phase_next    = phase_reg;
        id_idx_next   = id_idx_reg;
        data_idx_next = data_idx_reg;
        length_next   = length_reg;
        id_next       = id_reg;
        done          = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (byte_data == SYNC_A)
                begin
                    phase_next = PH_SYNC_B;
                end
            end
            PH_SYNC_B:
            begin
                if (byte_data == SYNC_B)
                begin
                    phase_next = PH_SYNC_C;
                end
                else if (byte_data != SYNC_A)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_SYNC_C:
            begin
                phase_next  = (byte_data == SYNC_C) ? PH_ID : PH_HUNT;
                id_idx_next = '0;
            end
            PH_ID:
            begin
                id_next[8*id_idx_reg +: 8] = byte_data;
                id_idx_next = id_idx_reg + ID_IDX_W'(1);
                if (id_idx_reg == ID_IDX_W'(ID_BYTES - 1))
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                length_next   = len_sat;
                data_idx_next = '0;
                if (len_sat == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                data_idx_next = data_idx_reg + IDX_W'(1);
                if (data_count >= length_reg)
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
        if (done)
        begin
            phase_next = PH_HUNT;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            id_idx_reg   <= '0;
            data_idx_reg <= '0;
            length_reg   <= '0;
        end
        else if (byte_valid)
        begin
            phase_reg    <= phase_next;
            id_idx_reg   <= id_idx_next;
            data_idx_reg <= data_idx_next;
            length_reg   <= length_next;
        end
    end

    // Identifier and payload bytes; every field read is written earlier in the frame.
    always_ff @(posedge clk)
    begin
        if (byte_valid)
        begin
            id_reg <= id_next;
            if (phase_reg == PH_DATA)
            begin
                store_reg[data_idx_reg] <= byte_data;
            end
        end
    end

    // Record assembly: the final data byte bypasses the store.
    assign out_len = (phase_reg == PH_LEN) ? len_sat : length_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_LEN; k++)
        begin
            if (LEN_W'(k) >= out_len)
            begin
                lane[k] = '0;
            end
            else if (phase_reg == PH_DATA && data_idx_reg == IDX_W'(k))
            begin
                lane[k] = byte_data;
            end
            else
            begin
                lane[k] = store_reg[k];
            end
        end
    end

    assign rec_push              = byte_valid && done;
    assign rec_data.frame_id     = id_reg;
    assign rec_data.frame_length = out_len;
    assign rec_data.data_0       = lane[0];
    assign rec_data.data_1       = lane[1];
    assign rec_data.data_2       = lane[2];
    assign rec_data.data_3       = lane[3];
    assign rec_data.data_4       = lane[4];
    assign rec_data.data_5       = lane[5];
    assign rec_data.data_6       = lane[6];
    assign rec_data.data_7       = lane[7];

endmodule

>>> design/scrd_out_stage.sv
module scrd_out_stage
    import scrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  scrd_record_t push_data,
    output logic         can_accept,
    output logic         out_valid,
    input  logic         out_ready,
    output scrd_record_t out_data
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    scrd_record_t out_data_reg, out_data_next;
    scrd_record_t skid_data_reg, skid_data_next;

    // The skid entry catches a record when the output register is stalled.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

endmodule

>>> design/sync_framed_can_record_deframer_unit.sv
// Output: a record is registered by the output stage on the transaction
// carrying its last byte (the length byte when the length is zero).
// Throughput: one byte per cycle while the skid entry is empty; the parser
// steps once per byte, and a two-entry output and skid stage absorb stalls.
// Reset: rst_n clears the parser to hunting for the first sync byte and
// empties the output stage; payload bytes are undefined until written.
module sync_framed_can_record_deframer_unit
    import scrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    scrd_byte_if.sink  rx,
    scrd_rec_if.source rec
);

    logic         byte_accept;
    logic         rec_push;
    logic         can_accept;
    scrd_record_t rec_data;
    scrd_record_t out_data;

    assign rx.ready    = can_accept;
    assign byte_accept = rx.valid && can_accept;

    // Byte parser.
    scrd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .byte_data  (rx.rx_byte),
        .rec_push   (rec_push),
        .rec_data   (rec_data)
    );

    // Result register with skid entry.
    scrd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rec_push),
        .push_data  (rec_data),
        .can_accept (can_accept),
        .out_valid  (rec.valid),
        .out_ready  (rec.ready),
        .out_data   (out_data)
    );

    assign rec.frame_id     = out_data.frame_id;
    assign rec.frame_length = out_data.frame_length;
    assign rec.data_0       = out_data.data_0;
    assign rec.data_1       = out_data.data_1;
    assign rec.data_2       = out_data.data_2;
    assign rec.data_3       = out_data.data_3;
    assign rec.data_4       = out_data.data_4;
    assign rec.data_5       = out_data.data_5;
    assign rec.data_6       = out_data.data_6;
    assign rec.data_7       = out_data.data_7;

endmodule

>>> test/tb_sync_framed_can_record_deframer_unit.sv
module tb_sync_framed_can_record_deframer_unit
    import scrd_pkg::*;
;

    logic clk;
    logic rst_n;

    scrd_byte_if byte_ch();
    scrd_rec_if  rec_ch();

    sync_framed_can_record_deframer_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (byte_ch.sink),
        .rec   (rec_ch.source)
    );

    // Flow-control settings for the current phase, in percent.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Frame parser mirror used to predict the records.
    scrd_phase_t parse_ph;
    int unsigned id_slot;
    int unsigned data_slot;
    logic [31:0] id_acc;
    logic [3:0]  len_q;
    logic [7:0]  payload [MAX_LEN];

    // Records predicted but not yet seen on the output.
    scrd_record_t frames_due [$];

    // Run statistics.
    int unsigned n_errors;
    int unsigned n_frames;
    int unsigned bytes_sent;
    int unsigned bytes_parsed;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #3000000;
        $display("sync_framed_can_record_deframer_unit: mismatch");
        $finish;
    end

    // Receiver side: ready changes at the falling edge.
    initial
    begin
        rec_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rec_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Build a frame record from the parser mirror; unused payload reads as zero.
    function automatic scrd_record_t build_frame();
        scrd_record_t r;
        logic [7:0]   d [MAX_LEN];
        for (int k = 0; k < MAX_LEN; k++)
        begin
            d[k] = (k < len_q) ? payload[k] : 8'h00;
        end
        r.frame_id     = id_acc;
        r.frame_length = len_q;
        r.data_0 = d[0];
        r.data_1 = d[1];
        r.data_2 = d[2];
        r.data_3 = d[3];
        r.data_4 = d[4];
        r.data_5 = d[5];
        r.data_6 = d[6];
        r.data_7 = d[7];
        return r;
    endfunction

    // Advance the parser mirror by one accepted byte.
    task automatic parse_rx_byte(input logic [7:0] b);
        logic emit;
        emit = 1'b0;
        if (parse_ph != PH_HUNT || b == SYNC_A)
        begin
            bytes_parsed++;
        end
        case (parse_ph)
            PH_HUNT:
            begin
                if (b == SYNC_A)
                begin
                    id_acc   = '0;
                    len_q    = '0;
                    parse_ph = PH_SYNC_B;
                end
            end
            PH_SYNC_B:
            begin
                if (b == SYNC_B)
                begin
                    parse_ph = PH_SYNC_C;
                end
                else if (b != SYNC_A)
                begin
                    parse_ph = PH_HUNT;
                end
            end
            PH_SYNC_C:
            begin
                if (b == SYNC_C)
                begin
                    parse_ph = PH_ID;
                    id_slot  = 0;
                end
                else
                begin
                    parse_ph = PH_HUNT;
                end
            end
            PH_ID:
            begin
                id_acc |= 32'(b) << (8 * id_slot);
                if (id_slot == ID_BYTES - 1)
                begin
                    parse_ph = PH_LEN;
                end
                else
                begin
                    id_slot++;
                end
            end
            PH_LEN:
            begin
                len_q = (b > MAX_LEN) ? MAX_LEN_CODE : b[LEN_W-1:0];
                if (len_q == 0)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    parse_ph  = PH_DATA;
                    data_slot = 0;
                end
            end
            default:
            begin
                payload[data_slot] = b;
                if (data_slot + 1 >= len_q)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    data_slot++;
                end
            end
        endcase

        // A finished frame is queued and the parser goes back to the hunt.
        if (emit)
        begin
            frames_due.push_back(build_frame());
            parse_ph = PH_HUNT;
            id_acc   = '0;
            len_q    = '0;
        end
    endtask

    // Send one byte, with random idle cycles ahead of it, and predict on acceptance.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            byte_ch.valid   <= 1'b0;
            byte_ch.rx_byte <= 8'($urandom);
        end
        @(negedge clk);
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (byte_ch.ready !== 1'b1);
        bytes_sent++;
        parse_rx_byte(b);
    endtask

    // Stop sending until every predicted record has been seen.
    task automatic wait_all_frames();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (frames_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            n_errors++;
        end
    endtask

    // Compare every accepted record transaction with the oldest prediction.
    always @(posedge clk)
    begin
        scrd_record_t want;
        if (rst_n && rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1)
        begin
            if (frames_due.size() == 0)
            begin
                $error("frame record 0x%0h arrived with none pending", rec_ch.frame_id);
                n_errors++;
            end
            else
            begin
                want = frames_due.pop_front();
                n_frames++;
                check_field("frame_id", want.frame_id, rec_ch.frame_id);
                check_field("frame_length", 32'(want.frame_length), 32'(rec_ch.frame_length));
                check_field("data_0", 32'(want.data_0), 32'(rec_ch.data_0));
                check_field("data_1", 32'(want.data_1), 32'(rec_ch.data_1));
                check_field("data_2", 32'(want.data_2), 32'(rec_ch.data_2));
                check_field("data_3", 32'(want.data_3), 32'(rec_ch.data_3));
                check_field("data_4", 32'(want.data_4), 32'(rec_ch.data_4));
                check_field("data_5", 32'(want.data_5), 32'(rec_ch.data_5));
                check_field("data_6", 32'(want.data_6), 32'(rec_ch.data_6));
                check_field("data_7", 32'(want.data_7), 32'(rec_ch.data_7));
            end
        end
    end

    // Byte biased toward the extremes and the sync values.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 99) < 15)
        begin
            case ($urandom_range(0, 4))
                0: return 8'h00;
                1: return 8'hFF;
                2: return SYNC_A;
                3: return SYNC_B;
                default: return SYNC_C;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_sync();
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
    endtask

    // Repeated first sync byte, extreme identifier bytes and a zero length.
    task automatic test_zero_length();
        send_byte(SYNC_A);
        send_sync();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_all_frames();
    endtask

    // A wrong second byte and a wrong third byte both drop back to the hunt.
    task automatic test_sync_errors();
        send_byte(SYNC_A);
        send_byte(8'h00);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_A);
        wait_all_frames();
    endtask

    // Oversized length saturates to a full eight-byte payload.
    task automatic test_full_payload();
        send_sync();
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(SYNC_A);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(SYNC_C);
        wait_all_frames();
    endtask

    // Well-formed frame with random identifier, length and payload.
    task automatic send_random_frame();
        logic [7:0]  len_byte;
        int unsigned n_data;
        if ($urandom_range(0, 9) == 0)
        begin
            send_byte(SYNC_A);
        end
        send_sync();
        repeat (ID_BYTES) send_byte(pick_byte());
        if ($urandom_range(0, 99) < 75)
        begin
            len_byte = 8'($urandom_range(0, MAX_LEN));
        end
        else
        begin
            len_byte = 8'($urandom_range(MAX_LEN + 1, 255));
        end
        send_byte(len_byte);
        n_data = (len_byte > MAX_LEN) ? MAX_LEN : len_byte;
        repeat (n_data) send_byte(pick_byte());
    endtask

    // Mostly whole frames, with broken sync sequences and line noise mixed in.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned n_bytes);
        int unsigned start;
        int unsigned pause_at;
        int unsigned kind;
        logic        paused;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start    = bytes_parsed;
        pause_at = $urandom_range(n_bytes / 4, 3 * n_bytes / 4);
        paused   = 1'b0;
        while (bytes_parsed < start + n_bytes)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                send_random_frame();
                if (!paused && bytes_parsed >= start + pause_at)
                begin
                    wait_all_frames();
                    paused = 1'b1;
                end
            end
            else if (kind < 90)
            begin
                send_byte(SYNC_A);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_byte(SYNC_B);
                end
                send_byte(pick_byte());
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
        end
        wait_all_frames();
    endtask

    // Test sequence.
    initial
    begin
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'h00;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        parse_ph        = PH_HUNT;
        id_slot         = 0;
        data_slot       = 0;
        id_acc          = '0;
        len_q           = '0;
        n_errors        = 0;
        n_frames        = 0;
        bytes_sent      = 0;
        bytes_parsed    = 0;
        for (int k = 0; k < MAX_LEN; k++)
        begin
            payload[k] = 8'h00;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_length();
        test_sync_errors();
        test_full_payload();
        test_random_traffic(0, 0, 500);
        test_random_traffic(73, 0, 500);
        test_random_traffic(0, 73, 500);
        test_random_traffic(15, 15, 500);

        // Drain with the receiver always ready.
        recv_stall_pct = 0;
        wait_all_frames();
        repeat (8) @(posedge clk);
        if (frames_due.size() != 0)
        begin
            $error("%0d frame records never arrived", frames_due.size());
            n_errors++;
        end

        $display("Sent %0d bytes (%0d past the hunt) and checked %0d frame records",
                 bytes_sent, bytes_parsed, n_frames);
        $display("under free-running, sender-idle, receiver-stall and mixed flow control.");
        if (n_errors == 0)
        begin
            $display("sync_framed_can_record_deframer_unit: match");
        end
        else
        begin
            $display("sync_framed_can_record_deframer_unit: mismatch");
        end
        $finish;
    end

endmodule
